/* sv/wcq_pkg.sv */
// Package with the shared types, constants and grid helpers of the cell change qualifier.
package wcq_pkg;

  localparam int GRID_ROWS  = 8;
  localparam int GRID_COLS  = 8;
  localparam int WINDOW_LEN = 8;

  localparam int CELLS  = 64;
  localparam int POS_W  = $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int THR_W  = 4;
  localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int IDX_W  = 6;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3);
  localparam logic [CNT_W-1:0] AGE_FULL  = CNT_W'(WINDOW_LEN);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(WINDOW_LEN - 1);

  typedef struct packed {
    logic [63:0] sample_board;
    logic        log_moves;
  } in_word_t;

  typedef struct packed {
    logic        flip_valid;
    logic [2:0]  flip_row;
    logic [2:0]  flip_col;
    logic        new_value;
    logic        last_of_scan;
    logic [63:0] accepted_board;
  } out_word_t;

  function automatic logic [63:0] grid_mask();
    logic [63:0] m;
    m = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (r < GRID_ROWS && c < GRID_COLS) begin
          m[r*8+c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic logic [63:0] reset_board();
    logic [63:0] m;
    m = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (r < GRID_ROWS && c < GRID_COLS && (r <= 1 || r >= 6)) begin
          m[r*8+c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  localparam logic [63:0] GRID_MASK   = grid_mask();
  localparam logic [63:0] RESET_BOARD = reset_board();

endpackage

/* sv/wcq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module wcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/windowed_cell_change_qualifier_top.sv */
// Top level of the windowed cell change qualifier for an 8x8 presence sensor grid.
//
// Each input word carries one raw scan of the grid and a logging flag. A cell's
// change flag is set when its raw bit differs from its accepted value; the last
// eight flags per cell sit in a window memory, and a per-cell count tracks them.
// When a count reaches the threshold, the accepted bit toggles and the cell's
// history is dropped. With logging on, one output word per flipped cell leaves
// in row-major order; otherwise one empty word carries the board.
// The user writes the threshold through the configuration channel only while
// idle; the block does not enforce this. An input word is read from the window
// memory in the cycle it is accepted and updated as it leaves the update stage.
// A new scan is accepted every cycle while the input is not stalled; a scan that
// flips N cells with logging on leaves as N words, one per cycle while the
// receiver does not stall. While the receiver stalls, the output word holds, one
// finished scan waits behind it, and a third scan waits in the update stage
// before the input is stalled. Reset restores the starting position (rows 0, 1,
// 6 and 7 occupied), clears all counts and the threshold becomes 3. The window
// memory needs no clearing pass after reset.
module windowed_cell_change_qualifier_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wcq_pkg::THR_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wcq_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wcq_pkg::out_word_t            out_data
);

  logic [wcq_pkg::THR_W-1:0] threshold;
  logic [wcq_pkg::POS_W-1:0] pos;
  logic [63:0]               board;
  logic [wcq_pkg::CNT_W-1:0] cnt [wcq_pkg::CELLS];
  logic [wcq_pkg::CNT_W-1:0] age [wcq_pkg::CELLS];

  logic                      s1_valid;
  logic [63:0]               s1_sample;
  logic                      s1_log;
  logic [wcq_pkg::POS_W-1:0] s1_pos;

  logic        d_valid;
  logic [63:0] d_mask;
  logic [63:0] d_board;
  logic        d_log;

  logic [63:0]               rdata;
  logic [63:0]               chg;
  logic [63:0]               flip;
  logic [wcq_pkg::CNT_W-1:0] cnt_next [wcq_pkg::CELLS];
  logic [wcq_pkg::CNT_W-1:0] age_next [wcq_pkg::CELLS];

  logic                      in_go;
  logic                      s1_go;
  logic                      o_free;
  logic                      d_done;
  logic [63:0]               lowest;
  logic [63:0]               rest;
  logic [wcq_pkg::IDX_W-1:0] low_idx;
  logic                      evt_mode;
  wcq_pkg::out_word_t        result;

  assign cfg_ready = 1'b1;
  assign o_free    = !out_valid || !out_stall;
  assign evt_mode  = d_log && (d_mask != '0);
  assign lowest    = d_mask & (~d_mask + 64'd1);
  assign rest      = d_mask & ~lowest;
  assign d_done    = d_valid && o_free && (!evt_mode || (rest == '0));
  assign s1_go     = s1_valid && (!d_valid || d_done);
  assign in_stall  = s1_valid && !s1_go;
  assign in_go     = in_valid && !in_stall;

  wcq_ram #(
    .WIDTH(64),
    .DEPTH(wcq_pkg::WINDOW_LEN)
  ) u_window (
    .clk  (clk),
    .we   (s1_go),
    .waddr(s1_pos),
    .wdata(chg),
    .re   (in_go),
    .raddr(pos),
    .rdata(rdata)
  );

  always_comb begin
    logic                      prev;
    logic [wcq_pkg::CNT_W-1:0] upd;
    for (int b = 0; b < wcq_pkg::CELLS; b++) begin
      chg[b] = wcq_pkg::GRID_MASK[b] & (s1_sample[b] ^ board[b]);
      prev   = rdata[b] && (age[b] == wcq_pkg::AGE_FULL);
      if (chg[b] && !prev) begin
        upd = cnt[b] + wcq_pkg::CNT_W'(1);
      end else if (!chg[b] && prev && cnt[b] != '0) begin
        upd = cnt[b] - wcq_pkg::CNT_W'(1);
      end else begin
        upd = cnt[b];
      end
      flip[b] = wcq_pkg::GRID_MASK[b] &&
                (wcq_pkg::CMP_W'(upd) >= wcq_pkg::CMP_W'(threshold));
      cnt_next[b] = flip[b] ? '0 : upd;
      if (flip[b]) begin
        age_next[b] = '0;
      end else if (age[b] != wcq_pkg::AGE_FULL) begin
        age_next[b] = age[b] + wcq_pkg::CNT_W'(1);
      end else begin
        age_next[b] = age[b];
      end
    end
  end

  always_comb begin
    low_idx = '0;
    for (int b = 0; b < wcq_pkg::CELLS; b++) begin
      if (lowest[b]) begin
        low_idx = low_idx | wcq_pkg::IDX_W'(b);
      end
    end
    result = '0;
    result.accepted_board = d_board;
    if (evt_mode) begin
      result.flip_valid   = 1'b1;
      result.flip_row     = low_idx[5:3];
      result.flip_col     = low_idx[2:0];
      result.new_value    = d_board[low_idx];
      result.last_of_scan = (rest == '0);
    end else begin
      result.last_of_scan = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= wcq_pkg::THR_RESET;
      pos       <= '0;
      board     <= wcq_pkg::RESET_BOARD;
      s1_valid  <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
      for (int b = 0; b < wcq_pkg::CELLS; b++) begin
        cnt[b] <= '0;
        age[b] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      if (in_go) begin
        pos <= (pos == wcq_pkg::POS_LAST) ? '0 : pos + wcq_pkg::POS_W'(1);
      end
      if (in_go) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        board <= board ^ flip;
        for (int b = 0; b < wcq_pkg::CELLS; b++) begin
          cnt[b] <= cnt_next[b];
          age[b] <= age_next[b];
        end
      end
      if (s1_go) begin
        d_valid <= 1'b1;
      end else if (d_done) begin
        d_valid <= 1'b0;
      end
      if (o_free) begin
        out_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_sample <= in_data.sample_board;
      s1_log    <= in_data.log_moves;
      s1_pos    <= pos;
    end
    if (s1_go) begin
      d_mask  <= flip;
      d_board <= board ^ flip;
      d_log   <= s1_log;
    end else if (d_valid && o_free && evt_mode) begin
      d_mask <= rest;
    end
    if (o_free && d_valid) begin
      out_data <= result;
    end
  end

endmodule

/* sv/wcq_checker.sv */
// Port checker for the cell change qualifier and its bind to the top level.
module wcq_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input wcq_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output word changed or was dropped.");

  a_only_last_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_scan |-> out_data.flip_valid)
    else $error("A word other than the last of a scan carries no flip.");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.flip_valid |->
      out_data.flip_row == 3'd0 && out_data.flip_col == 3'd0 && !out_data.new_value)
    else $error("An empty result carries flip fields.");

  a_value_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.flip_valid |->
      out_data.new_value ==
        out_data.accepted_board[{out_data.flip_row, out_data.flip_col}])
    else $error("Flip value disagrees with the accepted board.");

endmodule

bind windowed_cell_change_qualifier_top wcq_checker u_wcq_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
